// File: rtl/core/gdc_pkg.sv
// gdc_pkg: request, response and internal record types for the date calculator,
// plus calendar helper functions (leap rule, month tables, constant divides).
// No dependencies.
package gdc_pkg;

	localparam logic [2:0] KIND_NEXT     = 3'd0;
	localparam logic [2:0] KIND_PREV     = 3'd1;
	localparam logic [2:0] KIND_WEEK     = 3'd2;
	localparam logic [2:0] KIND_ANNIV    = 3'd3;
	localparam logic [2:0] KIND_DURATION = 3'd4;

	localparam logic [13:0] YEAR_MAX = 14'd9999;

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [4:0]  other_day;
		logic [3:0]  other_month;
		logic [13:0] other_year;
	} req_t;

	typedef struct packed {
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [13:0] out_year;
		logic [21:0] day_count;
		logic        error;
	} rsp_t;

	// per-date values derived from one day/month/year triple
	typedef struct packed {
		logic        leap;
		logic        valid;
		logic        md_ok_leap;
		logic        after_feb;
		logic [8:0]  base;
		logic [8:0]  ord;
		logic [4:0]  dim;
		logic [21:0] dn;
	} date_info_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic        leap_next;
		date_info_t  prim;
		date_info_t  oth;
	} stage_t;

	// floor(v / 100), exact for v up to 10000
	function automatic logic [6:0] div100(input logic [14:0] v);
		logic [27:0] prod;
		prod = {13'd0, v} * 28'd5243;
		return prod[25:19];
	endfunction

	function automatic logic is_leap(input logic [14:0] y);
		logic [6:0]  q;
		logic [14:0] hund;
		q = div100(y);
		hund = 15'(q) * 15'd100;
		return (y[1:0] == 2'b00) && ((y != hund) || (q[1:0] == 2'b00));
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] s;
		case (m)
			4'd1:    s = 9'd0;
			4'd2:    s = 9'd31;
			4'd3:    s = 9'd59;
			4'd4:    s = 9'd90;
			4'd5:    s = 9'd120;
			4'd6:    s = 9'd151;
			4'd7:    s = 9'd181;
			4'd8:    s = 9'd212;
			4'd9:    s = 9'd243;
			4'd10:   s = 9'd273;
			4'd11:   s = 9'd304;
			4'd12:   s = 9'd334;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	// zero for a month code outside 1..12
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd2:                      n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7,
			4'd8, 4'd10, 4'd12:        n = 5'd31;
			default:                   n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

// File: rtl/core/gdc_date_info.sv
// gdc_date_info: validity, leap flag, ordinal and day number of one date.
// Depends on gdc_pkg.
module gdc_date_info import gdc_pkg::*; (
	input  logic [4:0]  day,
	input  logic [3:0]  month,
	input  logic [13:0] year,
	output date_info_t  info
);

	logic [13:0] prev_year;
	logic [6:0]  cent;
	logic [4:0]  dim_leap;

	always_comb begin
		info.leap       = is_leap({1'b0, year});
		info.dim        = month_len(month, info.leap);
		dim_leap        = month_len(month, 1'b1);
		info.valid      = (year != 14'd0) && (year <= YEAR_MAX) && (day != 5'd0)
		                  && (day <= info.dim);
		info.md_ok_leap = (day != 5'd0) && (day <= dim_leap);
		info.after_feb  = (month > 4'd2);
		info.base       = month_start(month) + 9'(day);
		info.ord        = info.base + 9'(info.leap && info.after_feb);

		// days since year 1 day 1: 365p + p/4 - p/100 + p/400 + ord - 1
		prev_year = year - 14'd1;
		cent      = div100({1'b0, prev_year});
		info.dn   = 22'(prev_year) * 22'd365 + 22'(prev_year[13:2]) - 22'(cent)
		            + 22'(cent[6:2]) + 22'(info.ord) - 22'd1;
	end

endmodule

// File: rtl/core/gdc_result.sv
// gdc_result: picks the answer for the request kind from the derived date values.
// Depends on gdc_pkg.
module gdc_result import gdc_pkg::*; (
	input  stage_t st,
	output rsp_t   rsp
);

	logic        err;
	logic [4:0]  rd;
	logic [3:0]  rm;
	logic [13:0] ry;
	logic [21:0] cnt;
	logic [20:0] wk_prod;
	logic [9:0]  ann;
	logic [9:0]  ylen;
	logic [9:0]  wrap_cnt;

	always_comb begin
		err = !st.prim.valid;
		rd  = st.day;
		rm  = st.month;
		ry  = st.year;
		cnt = '0;

		// ordinal / 7 by reciprocal, exact for ordinals up to 366
		wk_prod  = 21'(st.prim.ord) * 21'd2341;
		ann      = 10'(st.oth.base) + 10'(st.prim.leap && st.oth.after_feb);
		ylen     = st.prim.leap ? 10'd366 : 10'd365;
		wrap_cnt = ylen - 10'(st.prim.ord) + 10'(st.oth.base)
		           + 10'(st.leap_next && st.oth.after_feb);

		case (st.kind)
			KIND_NEXT: begin
				if (st.day < st.prim.dim) begin
					rd = st.day + 5'd1;
				end else if (st.month < 4'd12) begin
					rd = 5'd1;
					rm = st.month + 4'd1;
				end else if (st.year < YEAR_MAX) begin
					rd = 5'd1;
					rm = 4'd1;
					ry = st.year + 14'd1;
				end else begin
					err = 1'b1;
				end
			end
			KIND_PREV: begin
				if (st.day > 5'd1) begin
					rd = st.day - 5'd1;
				end else if (st.month > 4'd1) begin
					rm = st.month - 4'd1;
					rd = month_len(st.month - 4'd1, st.prim.leap);
				end else if (st.year > 14'd1) begin
					rd = 5'd31;
					rm = 4'd12;
					ry = st.year - 14'd1;
				end else begin
					err = 1'b1;
				end
			end
			KIND_WEEK: begin
				rd  = '0;
				rm  = '0;
				ry  = '0;
				cnt = 22'(wk_prod[20:14]) + 22'd1;
			end
			KIND_ANNIV: begin
				rd = '0;
				rm = '0;
				ry = '0;
				if (!st.oth.md_ok_leap) begin
					err = 1'b1;
				end else if (ann >= 10'(st.prim.ord)) begin
					cnt = 22'(ann - 10'(st.prim.ord));
				end else begin
					cnt = 22'(wrap_cnt);
				end
			end
			KIND_DURATION: begin
				rd = '0;
				rm = '0;
				ry = '0;
				if (!st.oth.valid) begin
					err = 1'b1;
				end else if (st.prim.dn > st.oth.dn) begin
					cnt = st.prim.dn - st.oth.dn;
				end else begin
					cnt = st.oth.dn - st.prim.dn;
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase

		if (err) begin
			rsp = '0;
			rsp.error = 1'b1;
		end else begin
			rsp.out_day   = rd;
			rsp.out_month = rm;
			rsp.out_year  = ry;
			rsp.day_count = cnt;
			rsp.error     = 1'b0;
		end
	end

endmodule

// File: rtl/core/gregorian_date_calculator_core.sv
// channel | signals                  | direction | accepted when
// req     | req_valid, req_ready, req | in        | req_valid && req_ready
// rsp     | rsp_valid, rsp_ready, rsp | out       | rsp_valid && rsp_ready
//
// one request per cycle while rsp_ready is high; rsp_valid marks the result register
// stages: input register, derived date values register, result register
// each stage advances when the one after it is empty or moving, so bubbles fill in
// while a result waits on rsp_ready
// arst_n clears all valid flags; payload registers are not reset
// Top level of the Gregorian date calculator. Depends on gdc_pkg, gdc_date_info,
// gdc_result.
module gregorian_date_calculator_core import gdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	req_t       req_s1;
	logic       v_s1;
	stage_t     st_s2;
	logic       v_s2;
	rsp_t       rsp_q;
	logic       rsp_valid_q;

	logic       ready_out;
	logic       ready_s2;
	logic       ready_s1;
	date_info_t prim_info;
	date_info_t oth_info;
	stage_t     st_next;
	rsp_t       rsp_next;

	assign ready_out = !rsp_valid_q || rsp_ready;
	assign ready_s2  = !v_s2 || ready_out;
	assign ready_s1  = !v_s1 || ready_s2;
	assign req_ready = ready_s1;

	gdc_date_info u_prim (
		.day   (req_s1.day),
		.month (req_s1.month),
		.year  (req_s1.year),
		.info  (prim_info)
	);

	gdc_date_info u_oth (
		.day   (req_s1.other_day),
		.month (req_s1.other_month),
		.year  (req_s1.other_year),
		.info  (oth_info)
	);

	always_comb begin
		st_next.kind      = req_s1.kind;
		st_next.day       = req_s1.day;
		st_next.month     = req_s1.month;
		st_next.year      = req_s1.year;
		// year 9999 rolls to 10000, a leap year, for the anniversary count
		st_next.leap_next = is_leap({1'b0, req_s1.year} + 15'd1);
		st_next.prim      = prim_info;
		st_next.oth       = oth_info;
	end

	gdc_result u_result (
		.st  (st_s2),
		.rsp (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= req_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_out) begin
				rsp_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && req_valid) begin
			req_s1 <= req;
		end
		if (ready_s2 && v_s1) begin
			st_s2 <= st_next;
		end
		if (ready_out && v_s2) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/core/gdc_checker.sv
// gdc_checker: port-level checks on the date calculator's request and response channels,
// bound to the top level. Depends on gdc_pkg.
module gdc_checker import gdc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// a waiting request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while waiting");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// rejected requests carry no date and no count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.error |-> rsp.out_day == 5'd0 && rsp.out_month == 4'd0
			&& rsp.out_year == 14'd0 && rsp.day_count == 22'd0)
		else $error("error response with nonzero fields");

	// a date answer and a count answer never come together
	a_date_no_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_day != 5'd0 |-> rsp.day_count == 22'd0)
		else $error("date response with nonzero count");

	// a returned date is in range
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.error && rsp.out_day != 5'd0 |->
			rsp.out_month != 4'd0 && rsp.out_month <= 4'd12 && rsp.out_year != 14'd0
			&& rsp.out_year <= YEAR_MAX)
		else $error("returned date out of range");

endmodule

bind gregorian_date_calculator_core gdc_checker u_gdc_checker (.*);
